// ===== src/wav_header_chunk_parser_macros.svh =====
// Assertion macros for the WAV header chunk parser.
// Included by whcp_parse_core, the RTL file that carries concurrent checks; depends on nothing.
`ifndef WAV_HEADER_CHUNK_PARSER_MACROS_SVH
`define WAV_HEADER_CHUNK_PARSER_MACROS_SVH

// Same-cycle implication, disabled during reset
`define WHCP_ASSERT_IMPLY(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset
`define WHCP_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/whcp_pkg.sv =====
// Shared types and constants of the WAV header chunk parser.
// No dependencies; imported by all parser modules.
`default_nettype none

package whcp_pkg;

   // Parse phases
   typedef enum logic [1:0] {
      PH_HEADER = 2'd0,
      PH_CHUNK  = 2'd1,
      PH_SKIP   = 2'd2,
      PH_DONE   = 2'd3
   } whcp_phase_type;

   // Result status codes
   typedef enum logic [1:0] {
      ST_OK     = 2'd0,
      ST_BAD    = 2'd1,
      ST_NODATA = 2'd2,
      ST_TRUNC  = 2'd3
   } whcp_status_type;

   // Tags as they sit in the little-endian shift register
   localparam logic [31:0] RIFF_TAG = 32'h4646_4952;
   localparam logic [31:0] WAVE_TAG = 32'h4556_4157;
   localparam logic [31:0] DATA_TAG = 32'h6174_6164;

   // Byte positions inside the fixed header
   localparam logic [5:0] POS_RIFF_END  = 6'd3;
   localparam logic [5:0] POS_WAVE_END  = 6'd11;
   localparam logic [5:0] POS_CHAN_LO   = 6'd22;
   localparam logic [5:0] POS_CHAN_HI   = 6'd23;
   localparam logic [5:0] POS_RATE_B0   = 6'd24;
   localparam logic [5:0] POS_RATE_B1   = 6'd25;
   localparam logic [5:0] POS_RATE_B2   = 6'd26;
   localparam logic [5:0] POS_RATE_B3   = 6'd27;
   localparam logic [5:0] POS_BITS_LO   = 6'd34;
   localparam logic [5:0] POS_HDR_LAST  = 6'd35;

   // Byte positions inside a chunk header
   localparam logic [5:0] POS_CTAG_END  = 6'd3;
   localparam logic [5:0] POS_CHDR_LAST = 6'd7;

   // One input byte
   typedef struct packed {
      logic [7:0] byte_in;
      logic       last_byte;
   } whcp_item_type;

   // One result
   typedef struct packed {
      whcp_status_type status;
      logic [31:0]     payload_bytes;
      logic [15:0]     channel_count;
      logic [31:0]     frame_rate;
      logic [15:0]     sample_bits;
   } whcp_result_type;

endpackage

`default_nettype wire

// ===== src/whcp_if.sv =====
// Valid/ready channel interfaces of the WAV header chunk parser.
// No dependencies; used by the parser top level and its stages.
`default_nettype none

// Byte stream channel
interface whcp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] byte_in;
   logic       last_byte;

   modport source (output valid, output byte_in, output last_byte, input ready);
   modport sink   (input valid, input byte_in, input last_byte, output ready);
endinterface

// Result channel
interface whcp_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [31:0] payload_bytes;
   logic [15:0] channel_count;
   logic [31:0] frame_rate;
   logic [15:0] sample_bits;

   modport source (output valid, output status, output payload_bytes, output channel_count,
                   output frame_rate, output sample_bits, input ready);
   modport sink   (input valid, input status, input payload_bytes, input channel_count,
                   input frame_rate, input sample_bits, output ready);
endinterface

`default_nettype wire

// ===== src/whcp_in_stage.sv =====
// Input register of the WAV header chunk parser.
// Depends on whcp_pkg and whcp_req_if.
`default_nettype none

module whcp_in_stage import whcp_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   whcp_req_if.sink     req_chan,
   output whcp_item_type item_o,
   output logic         item_valid_o,
   input  wire logic    item_take_i
);

   logic          valid_ff, valid_in;
   whcp_item_type item_ff, item_in;

   // Register is free when empty or being drained this cycle
   assign req_chan.ready = !valid_ff || item_take_i;

   always_comb begin
      valid_in = req_chan.ready ? req_chan.valid : valid_ff;
      item_in  = item_ff;
      if (req_chan.valid && req_chan.ready) begin
         item_in.byte_in   = req_chan.byte_in;
         item_in.last_byte = req_chan.last_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

   assign item_o       = item_ff;
   assign item_valid_o = valid_ff;

endmodule

`default_nettype wire

// ===== src/whcp_parse_core.sv =====
// Parse state and per-byte decode of the WAV header chunk parser.
// Depends on whcp_pkg and wav_header_chunk_parser_macros.svh.
`default_nettype none

`include "wav_header_chunk_parser_macros.svh"

module whcp_parse_core import whcp_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire whcp_item_type item_i,
   input  wire logic     item_valid_i,
   output logic          item_take_o,
   input  wire logic     out_free_i,
   output logic          rsp_valid_o,
   output whcp_result_type rsp_data_o
);

   whcp_phase_type phase_ff, phase_in;
   logic [5:0]     pos_ff, pos_in;
   logic [31:0]    tag_ff, tag_in;
   logic [31:0]    chunk_len_ff, chunk_len_in;
   logic [31:0]    skip_ff, skip_in;
   logic [15:0]    chan_ff, chan_in;
   logic [31:0]    rate_ff, rate_in;
   logic [15:0]    bits_ff, bits_in;
   logic           tags_ok_ff, tags_ok_in;

   logic            emit;
   whcp_status_type emit_status;
   logic [31:0]     emit_size;
   logic [31:0]     skip_dec;
   logic [7:0]      b;
   logic            last;

   assign b        = item_i.byte_in;
   assign last     = item_i.last_byte;
   assign skip_dec = skip_ff - 32'd1;

   // Next phase
   always_comb begin
      phase_in = phase_ff;
      case (phase_ff)
         PH_HEADER: begin
            if (pos_ff >= POS_HDR_LAST) begin
               if (!tags_ok_in) begin
                  phase_in = PH_DONE;
               end else if (!last) begin
                  phase_in = PH_CHUNK;
               end
            end
         end
         PH_CHUNK: begin
            if (pos_ff >= POS_CHDR_LAST) begin
               if (chunk_len_ff == DATA_TAG) begin
                  phase_in = PH_DONE;
               end else if (!last && tag_in != '0) begin
                  phase_in = PH_SKIP;
               end
            end
         end
         PH_SKIP: begin
            if (!last && skip_dec == '0) begin
               phase_in = PH_CHUNK;
            end
         end
         default: begin
            phase_in = phase_ff;
         end
      endcase
   end

   // Datapath and result decode
   always_comb begin
      tag_in       = {b, tag_ff[31:8]};
      pos_in       = pos_ff;
      chunk_len_in = chunk_len_ff;
      skip_in      = skip_ff;
      chan_in      = chan_ff;
      rate_in      = rate_ff;
      bits_in      = bits_ff;
      tags_ok_in   = tags_ok_ff;
      emit         = 1'b0;
      emit_status  = ST_OK;
      emit_size    = '0;

      case (phase_ff)
         PH_HEADER: begin
            if (pos_ff == POS_RIFF_END && tag_in != RIFF_TAG) begin
               tags_ok_in = 1'b0;
            end
            if (pos_ff == POS_WAVE_END && tag_in != WAVE_TAG) begin
               tags_ok_in = 1'b0;
            end
            // Field capture, little endian
            case (pos_ff)
               POS_CHAN_LO:  chan_in[7:0]    = b;
               POS_CHAN_HI:  chan_in[15:8]   = b;
               POS_RATE_B0:  rate_in[7:0]    = b;
               POS_RATE_B1:  rate_in[15:8]   = b;
               POS_RATE_B2:  rate_in[23:16]  = b;
               POS_RATE_B3:  rate_in[31:24]  = b;
               POS_BITS_LO:  bits_in[7:0]    = b;
               POS_HDR_LAST: bits_in[15:8]   = b;
               default: begin
               end
            endcase
            if (pos_ff >= POS_HDR_LAST) begin
               if (!tags_ok_in) begin
                  emit        = 1'b1;
                  emit_status = ST_BAD;
               end else if (last) begin
                  emit        = 1'b1;
                  emit_status = ST_NODATA;
               end else begin
                  pos_in = '0;
               end
            end else if (last) begin
               emit        = 1'b1;
               emit_status = ST_TRUNC;
            end else begin
               pos_in = pos_ff + 6'd1;
            end
         end
         PH_CHUNK: begin
            // Tag parks in chunk_len until the size word is complete
            if (pos_ff == POS_CTAG_END) begin
               chunk_len_in = tag_in;
            end
            if (pos_ff >= POS_CHDR_LAST) begin
               chunk_len_in = tag_in;
               if (chunk_len_ff == DATA_TAG) begin
                  emit        = 1'b1;
                  emit_status = ST_OK;
                  emit_size   = tag_in;
               end else if (last) begin
                  emit        = 1'b1;
                  emit_status = ST_NODATA;
               end else if (tag_in == '0) begin
                  pos_in = '0;
               end else begin
                  skip_in = tag_in;
                  pos_in  = '0;
               end
            end else if (last) begin
               emit        = 1'b1;
               emit_status = ST_NODATA;
            end else begin
               pos_in = pos_ff + 6'd1;
            end
         end
         PH_SKIP: begin
            if (last) begin
               emit        = 1'b1;
               emit_status = ST_NODATA;
            end else begin
               skip_in = skip_dec;
               if (skip_dec == '0) begin
                  pos_in = '0;
               end
            end
         end
         default: begin
         end
      endcase
   end

   // Handshake toward the output register
   assign item_take_o = item_valid_i && (!emit || out_free_i);
   assign rsp_valid_o = item_take_o && emit;

   always_comb begin
      rsp_data_o.status        = emit_status;
      rsp_data_o.payload_bytes = emit_size;
      rsp_data_o.channel_count = chan_in;
      rsp_data_o.frame_rate    = rate_in;
      rsp_data_o.sample_bits   = bits_in;
   end

   // State registers; the last byte rearms everything
   always_ff @(posedge clock) begin
      if (reset || (item_take_o && last)) begin
         phase_ff     <= PH_HEADER;
         pos_ff       <= '0;
         tag_ff       <= '0;
         chunk_len_ff <= '0;
         skip_ff      <= '0;
         chan_ff      <= '0;
         rate_ff      <= '0;
         bits_ff      <= '0;
         tags_ok_ff   <= 1'b1;
      end else if (item_take_o) begin
         phase_ff     <= phase_in;
         pos_ff       <= pos_in;
         tag_ff       <= tag_in;
         chunk_len_ff <= chunk_len_in;
         skip_ff      <= skip_in;
         chan_ff      <= chan_in;
         rate_ff      <= rate_in;
         bits_ff      <= bits_in;
         tags_ok_ff   <= tags_ok_in;
      end
   end

   // Checks
   `WHCP_ASSERT_IMPLY(a_hdr_pos_range, clock, reset, phase_ff == PH_HEADER,
      pos_ff <= POS_HDR_LAST, "header byte position out of range")
   `WHCP_ASSERT_IMPLY(a_size_only_ok, clock, reset,
      rsp_valid_o && rsp_data_o.status != ST_OK, rsp_data_o.payload_bytes == '0,
      "nonzero data size on a failing status")
   `WHCP_ASSERT_NEXT(a_last_rearms, clock, reset, item_take_o && last,
      phase_ff == PH_HEADER && pos_ff == '0 && tags_ok_ff, "last byte did not rearm parser")
   `WHCP_ASSERT_IMPLY(a_no_result_in_done, clock, reset,
      phase_ff == PH_DONE, !rsp_valid_o, "result produced after parse finished")

endmodule

`default_nettype wire

// ===== src/whcp_out_stage.sv =====
// Result register of the WAV header chunk parser.
// Depends on whcp_pkg and whcp_rsp_if.
`default_nettype none

module whcp_out_stage import whcp_pkg::*; (
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      load_i,
   input  wire whcp_result_type data_i,
   output logic           free_o,
   whcp_rsp_if.source     rsp_chan
);

   logic            valid_ff, valid_in;
   whcp_result_type data_ff, data_in;

   // Empty, or the held transaction leaves this cycle
   assign free_o = !valid_ff || rsp_chan.ready;

   always_comb begin
      valid_in = load_i || (valid_ff && !rsp_chan.ready);
      data_in  = load_i ? data_i : data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign rsp_chan.valid         = valid_ff;
   assign rsp_chan.status        = data_ff.status;
   assign rsp_chan.payload_bytes = data_ff.payload_bytes;
   assign rsp_chan.channel_count = data_ff.channel_count;
   assign rsp_chan.frame_rate    = data_ff.frame_rate;
   assign rsp_chan.sample_bits   = data_ff.sample_bits;

endmodule

`default_nettype wire

// ===== src/wav_header_chunk_parser.sv =====
// Path: a result reaches rsp_chan through the input register, then the result register.
// Throughput: one byte per cycle; a byte that yields a result waits in the input
// register only while the result register still holds an unaccepted transaction.
// Reset: synchronous, active high; clears both stage valids and the parse state.
// The byte marked last also returns the parse state to its reset values.
`default_nettype none

module wav_header_chunk_parser import whcp_pkg::*; (
   input  wire logic  clock,
   input  wire logic  reset,
   whcp_req_if.sink   req_chan,
   whcp_rsp_if.source rsp_chan
);

   whcp_item_type   item;
   logic            item_valid;
   logic            item_take;
   logic            out_free;
   logic            rsp_load;
   whcp_result_type rsp_data;

   // Input register
   whcp_in_stage u_in_stage (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .item_o      (item),
      .item_valid_o(item_valid),
      .item_take_i (item_take)
   );

   // Header and chunk walk
   whcp_parse_core u_parse_core (
      .clock       (clock),
      .reset       (reset),
      .item_i      (item),
      .item_valid_i(item_valid),
      .item_take_o (item_take),
      .out_free_i  (out_free),
      .rsp_valid_o (rsp_load),
      .rsp_data_o  (rsp_data)
   );

   // Result register
   whcp_out_stage u_out_stage (
      .clock   (clock),
      .reset   (reset),
      .load_i  (rsp_load),
      .data_i  (rsp_data),
      .free_o  (out_free),
      .rsp_chan(rsp_chan)
   );

endmodule

`default_nettype wire

// ===== verif/wav_header_chunk_parser_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for wav_header_chunk_parser: streams WAV files byte by byte
// and compares every result against a predictor; depends on whcp_pkg and whcp_if.

module wav_header_chunk_parser_tb;
   import whcp_pkg::*;

   localparam int CLK_HALF     = 5;
   localparam int RESET_CYCLES = 11;
   localparam int BYTE_TARGET  = 1550;
   localparam int HOLD_START   = 500;
   localparam int HOLD_LEN     = 400;
   localparam int DRAIN_LIMIT  = 20000;
   localparam int TAIL_CYCLES  = 8;

   // Shapes of generated files
   typedef enum int {
      SHAPE_GOOD,
      SHAPE_DATA_LAST,
      SHAPE_BAD_RIFF,
      SHAPE_BAD_WAVE,
      SHAPE_NOISE
   } file_shape_type;

   // Receiver pacing modes
   typedef enum int {
      PACE_OPEN,
      PACE_LIGHT,
      PACE_HEAVY
   } pace_mode_type;

   // Predicts the parser results and checks the ones that come back
   class wav_parse_checker;
      whcp_phase_type  stage;
      logic [5:0]      pos;
      logic [31:0]     tag_shift;
      logic [31:0]     chunk_len;
      logic [31:0]     skip_left;
      logic [15:0]     chan_word;
      logic [31:0]     rate_word;
      logic [15:0]     width_word;
      bit              tags_ok;
      whcp_result_type pending_results[$];
      int              mismatch_count;

      function new();
         mismatch_count = 0;
         clear();
      endfunction

      function void clear();
         stage      = PH_HEADER;
         pos        = '0;
         tag_shift  = '0;
         chunk_len  = '0;
         skip_left  = '0;
         chan_word  = '0;
         rate_word  = '0;
         width_word = '0;
         tags_ok    = 1'b1;
      endfunction

      function void push_result(whcp_status_type st, logic [31:0] size);
         whcp_result_type r;
         r.status        = st;
         r.payload_bytes = size;
         r.channel_count = chan_word;
         r.frame_rate    = rate_word;
         r.sample_bits   = width_word;
         pending_results.push_back(r);
      endfunction

      // One accepted byte transaction
      function void take_byte(logic [7:0] b, logic last);
         logic [31:0] tag;
         tag_shift = {b, tag_shift[31:8]};
         case (stage)
            PH_HEADER: begin
               if (pos == POS_RIFF_END && tag_shift != RIFF_TAG) tags_ok = 1'b0;
               if (pos == POS_WAVE_END && tag_shift != WAVE_TAG) tags_ok = 1'b0;
               if (pos == POS_CHAN_LO) chan_word[7:0] = b;
               if (pos == POS_CHAN_HI) chan_word[15:8] = b;
               if (pos >= POS_RATE_B0 && pos <= POS_RATE_B3)
                  rate_word = rate_word | (32'(b) << (8 * (pos - POS_RATE_B0)));
               if (pos == POS_BITS_LO) width_word[7:0] = b;
               if (pos == POS_HDR_LAST) width_word[15:8] = b;
               if (pos >= POS_HDR_LAST) begin
                  if (!tags_ok) begin
                     push_result(ST_BAD, '0);
                     stage = PH_DONE;
                  end else if (last) begin
                     push_result(ST_NODATA, '0);
                  end else begin
                     stage = PH_CHUNK;
                     pos   = '0;
                  end
               end else if (last) begin
                  push_result(ST_TRUNC, '0);
               end else begin
                  pos = pos + 6'd1;
               end
            end
            PH_CHUNK: begin
               // tag parks in chunk_len until the size word is complete
               if (pos == POS_CTAG_END) chunk_len = tag_shift;
               if (pos >= POS_CHDR_LAST) begin
                  tag       = chunk_len;
                  chunk_len = tag_shift;
                  if (tag == DATA_TAG) begin
                     push_result(ST_OK, tag_shift);
                     stage = PH_DONE;
                  end else if (last) begin
                     push_result(ST_NODATA, '0);
                  end else if (tag_shift == 32'd0) begin
                     pos = '0;
                  end else begin
                     skip_left = tag_shift;
                     stage     = PH_SKIP;
                     pos       = '0;
                  end
               end else if (last) begin
                  push_result(ST_NODATA, '0);
               end else begin
                  pos = pos + 6'd1;
               end
            end
            PH_SKIP: begin
               if (last) begin
                  push_result(ST_NODATA, '0);
               end else begin
                  skip_left = skip_left - 32'd1;
                  if (skip_left == 32'd0) begin
                     stage = PH_CHUNK;
                     pos   = '0;
                  end
               end
            end
            default: ;
         endcase
         if (last) clear();
      endfunction

      function void check_field(string name, logic [31:0] want, logic [31:0] got);
         if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatch_count++;
         end
      endfunction

      // One accepted result transaction
      function void check_result(whcp_result_type got);
         whcp_result_type want;
         if (pending_results.size() == 0) begin
            $error("result with nothing pending: status %0d size %0h",
                   got.status, got.payload_bytes);
            mismatch_count++;
         end else begin
            want = pending_results.pop_front();
            check_field("status", 32'(want.status), 32'(got.status));
            check_field("payload_bytes", want.payload_bytes, got.payload_bytes);
            check_field("channel_count", 32'(want.channel_count), 32'(got.channel_count));
            check_field("frame_rate", want.frame_rate, got.frame_rate);
            check_field("sample_bits", 32'(want.sample_bits), 32'(got.sample_bits));
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;

   whcp_req_if req_chan ();
   whcp_rsp_if rsp_chan ();

   wav_header_chunk_parser DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   wav_parse_checker tracker = new();
   int burst_left  = 0;
   int bytes_sent  = 0;

   // Clock
   always begin
      #CLK_HALF clock = 1'b1;
      #CLK_HALF clock = 1'b0;
   end

   // Input monitor: feed the predictor
   always @(posedge clock) begin
      if (!reset && req_chan.valid && req_chan.ready)
         tracker.take_byte(req_chan.byte_in, req_chan.last_byte);
   end

   // Result monitor
   always @(posedge clock) begin
      whcp_result_type got;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         got.status        = whcp_status_type'(rsp_chan.status);
         got.payload_bytes = rsp_chan.payload_bytes;
         got.channel_count = rsp_chan.channel_count;
         got.frame_rate    = rsp_chan.frame_rate;
         got.sample_bits   = rsp_chan.sample_bits;
         tracker.check_result(got);
      end
   end

   // Receiver pacing, with one long hold-off to back up the pipeline
   initial begin : rsp_pacing
      int            cyc;
      int            left;
      pace_mode_type mode;
      logic          rdy;
      cyc  = 0;
      left = 0;
      mode = PACE_OPEN;
      rsp_chan.ready = 1'b0;
      wait (reset === 1'b0);
      forever begin
         @(negedge clock);
         cyc++;
         if (left == 0) begin
            mode = pace_mode_type'($urandom_range(0, 2));
            left = $urandom_range(10, 200);
         end
         left--;
         if (cyc >= HOLD_START && cyc < HOLD_START + HOLD_LEN) begin
            rdy = 1'b0;
         end else begin
            case (mode)
               PACE_OPEN:  rdy = 1'b1;
               PACE_LIGHT: rdy = ($urandom_range(0, 3) != 0);
               default:    rdy = ($urandom_range(0, 7) == 0);
            endcase
         end
         rsp_chan.ready <= rdy;
      end
   end

   // Offer one byte transaction; random gaps fall between bursts
   task automatic send_byte(input logic [7:0] b, input logic last);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_chan.valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_chan.valid     <= 1'b1;
      req_chan.byte_in   <= b;
      req_chan.last_byte <= last;
      do @(posedge clock); while (!req_chan.ready);
      bytes_sent++;
      @(negedge clock);
   endtask

   function automatic void put_word(ref logic [7:0] q[$], input logic [31:0] w);
      for (int i = 0; i < 4; i++) q.push_back(w[8*i +: 8]);
   endfunction

   // Build one file and stream it; cut_at < 0 picks a random cut, 0 keeps it whole
   task automatic play_file(input file_shape_type shape, input int cut_at);
      logic [7:0]  fb[$];
      logic [31:0] tag;
      int          n_extra;
      int          size;
      int          len;
      int          k;
      if (shape == SHAPE_NOISE) begin
         len = $urandom_range(1, 70);
         repeat (len) fb.push_back(8'($urandom()));
      end else begin
         // fixed header
         put_word(fb, RIFF_TAG);
         put_word(fb, $urandom());
         put_word(fb, WAVE_TAG);
         repeat (24) fb.push_back(8'($urandom()));
         if (shape == SHAPE_BAD_RIFF) begin
            k = $urandom_range(0, 3);
            fb[k] = fb[k] ^ 8'($urandom_range(1, 255));
         end
         if (shape == SHAPE_BAD_WAVE) begin
            k = $urandom_range(8, 11);
            fb[k] = fb[k] ^ 8'($urandom_range(1, 255));
         end
         // chunks to skip, zero length now and then
         n_extra = $urandom_range(0, 3);
         repeat (n_extra) begin
            tag = $urandom();
            if (tag == DATA_TAG) tag = tag ^ 32'h1;
            size = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            put_word(fb, tag);
            put_word(fb, size);
            repeat (size) fb.push_back(8'($urandom()));
         end
         put_word(fb, DATA_TAG);
         put_word(fb, $urandom());
         // bytes after the data header are ignored; the last one rearms the parser
         if (shape != SHAPE_DATA_LAST)
            repeat ($urandom_range(0, 6)) fb.push_back(8'($urandom()));
      end
      if (cut_at < 0 && fb.size() > 1) begin
         len = $urandom_range(1, fb.size() - 1);
         fb  = fb[0:len-1];
      end else if (cut_at > 0 && cut_at < fb.size()) begin
         fb = fb[0:cut_at-1];
      end
      foreach (fb[i]) send_byte(fb[i], i == fb.size() - 1);
   endtask

   // Hard stop
   initial begin : watchdog
      #3_000_000;
      $display("wav_header_chunk_parser: mismatch");
      $finish;
   end

   // Main sequence
   initial begin : stimulus
      file_shape_type shape;
      int             r;
      int             waited;
      reset              = 1'b1;
      req_chan.valid     = 1'b0;
      req_chan.byte_in   = 8'h00;
      req_chan.last_byte = 1'b0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: lone last bytes at both byte extremes, short stream
      send_byte(8'h00, 1'b1);
      send_byte(8'hFF, 1'b1);
      send_byte("R", 1'b0);
      send_byte("I", 1'b0);
      send_byte("F", 1'b1);

      // Directed files: each way a stream can end
      play_file(SHAPE_GOOD, 0);
      play_file(SHAPE_DATA_LAST, 0);
      play_file(SHAPE_BAD_RIFF, 0);
      play_file(SHAPE_BAD_WAVE, 0);
      play_file(SHAPE_BAD_RIFF, 20);
      play_file(SHAPE_GOOD, 36);
      play_file(SHAPE_GOOD, 40);
      play_file(SHAPE_NOISE, 0);

      // Random files, mostly well formed
      while (bytes_sent < BYTE_TARGET) begin
         r = $urandom_range(0, 9);
         case (r)
            4:       shape = SHAPE_DATA_LAST;
            5:       shape = SHAPE_BAD_RIFF;
            6:       shape = SHAPE_BAD_WAVE;
            7:       shape = SHAPE_NOISE;
            default: shape = SHAPE_GOOD;
         endcase
         if (shape != SHAPE_DATA_LAST && $urandom_range(0, 3) == 0)
            play_file(shape, -1);
         else
            play_file(shape, 0);
      end
      req_chan.valid <= 1'b0;

      // Drain
      waited = 0;
      while (tracker.pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (TAIL_CYCLES) @(posedge clock);
      if (tracker.pending_results.size() == 0 && tracker.mismatch_count == 0)
         $display("wav_header_chunk_parser: match");
      else
         $display("wav_header_chunk_parser: mismatch");
      $finish;
   end

endmodule
